@@ sv/pngdf_pkg.sv @@
// Shared types, constants and the CRC-32 byte step for the PNG chunk deframer.
package pngdf_pkg;

    localparam int REG_IDX_W  = 3;
    localparam int REG_ADDR_W = REG_IDX_W + 2;

    localparam logic [REG_IDX_W-1:0] REG_TYPE_FIRST = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_IN_USE     = 3'd4;

    localparam logic [1:0] PH_LENGTH = 2'd0;
    localparam logic [1:0] PH_TYPE   = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_CRC    = 2'd3;

    localparam logic [1:0]  FIELD_LAST_BYTE = 2'd3;
    localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0]  byte_val;
        logic [1:0]  phase;
        logic        is_required;
        logic [31:0] chunk_type;
        logic        chunk_last;
    } t_work;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

@@ sv/pngdf_in_if.sv @@
// Input byte channel: valid/ready handshake carrying one stream byte per word.
interface pngdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

@@ sv/pngdf_out_if.sv @@
// Result channel: valid/ready handshake carrying one classified byte per word.
interface pngdf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic [1:0]  phase;
    logic        is_required;
    logic [31:0] chunk_type;
    logic        chunk_last;
    logic        crc_ok;

    modport source (output valid, output byte_out, output phase, output is_required,
                    output chunk_type, output chunk_last, output crc_ok, input ready);
    modport sink   (input valid, input byte_out, input phase, input is_required,
                    input chunk_type, input chunk_last, input crc_ok, output ready);
endinterface

@@ sv/pngdf_front.sv @@
// Front end: field tracking, length countdown, type capture and required-type match.
module pngdf_front #(
    parameter int REQUIRED_SLOTS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    output logic                o_ready,
    input  logic [31:0]         i_req_type [REQUIRED_SLOTS],
    input  logic [2:0]          i_req_in_use,
    output logic                o_push,
    output pngdf_pkg::t_work    o_work,
    input  logic                i_q_ready
);
    import pngdf_pkg::*;

    typedef enum logic [3:0] {
        FLD_LENGTH = 4'b0001,
        FLD_TYPE   = 4'b0010,
        FLD_DATA   = 4'b0100,
        FLD_CRC    = 4'b1000
    } t_field;

    t_field      r_state, n_state;
    logic [1:0]  r_cnt, n_cnt;
    logic [31:0] r_len, n_len;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_type, n_type;
    logic        r_match, n_match;
    logic [31:0] type_sh;
    logic        hit;
    logic        take;

    assign o_ready = i_q_ready;
    assign take    = i_valid && i_q_ready;
    assign o_push  = take;
    assign type_sh = {r_type[23:0], i_byte};

    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < REQUIRED_SLOTS; i++) begin
            if ((i_req_in_use > 3'(i)) && (i_req_type[i] == type_sh)) begin
                hit = 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_len   = r_len;
        n_rem   = r_rem;
        n_type  = r_type;
        n_match = r_match;
        o_work.byte_val    = i_byte;
        o_work.phase       = PH_LENGTH;
        o_work.is_required = 1'b0;
        o_work.chunk_type  = 32'h0;
        o_work.chunk_last  = 1'b0;
        case (r_state)
            FLD_LENGTH: begin
                n_len = {r_len[23:0], i_byte};
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == FIELD_LAST_BYTE) begin
                    n_state = FLD_TYPE;
                    n_type  = 32'h0;
                    n_match = 1'b0;
                end
            end
            FLD_TYPE: begin
                o_work.phase = PH_TYPE;
                n_type = type_sh;
                n_cnt  = r_cnt + 2'd1;
                if (r_cnt == FIELD_LAST_BYTE) begin
                    n_match            = hit;
                    o_work.is_required = hit;
                    o_work.chunk_type  = type_sh;
                    n_rem              = r_len;
                    n_state            = (r_len == 32'h0) ? FLD_CRC : FLD_DATA;
                end
            end
            FLD_DATA: begin
                o_work.phase       = PH_DATA;
                o_work.is_required = r_match;
                o_work.chunk_type  = r_type;
                n_rem = r_rem - {31'h0, (r_rem != 32'h0)};
                if (n_rem == 32'h0) begin
                    n_cnt   = 2'd0;
                    n_state = FLD_CRC;
                end
            end
            FLD_CRC: begin
                o_work.phase       = PH_CRC;
                o_work.is_required = r_match;
                o_work.chunk_type  = r_type;
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == FIELD_LAST_BYTE) begin
                    o_work.chunk_last = 1'b1;
                    n_len   = 32'h0;
                    n_rem   = 32'h0;
                    n_type  = 32'h0;
                    n_match = 1'b0;
                    n_state = FLD_LENGTH;
                end
            end
            default: begin
                n_state = FLD_LENGTH;
                n_cnt   = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FLD_LENGTH;
            r_cnt   <= 2'd0;
            r_match <= 1'b0;
        end else if (take) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_len  <= n_len;
            r_rem  <= n_rem;
            r_type <= n_type;
        end
    end

    a_len_to_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && (r_state == FLD_LENGTH) && (r_cnt == FIELD_LAST_BYTE) |=> r_state == FLD_TYPE)
        else $error("length field did not advance to type field");

endmodule

@@ sv/pngdf_fifo.sv @@
// Short word queue between the front end and the CRC back end.
module pngdf_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pngdf_pkg::t_work    i_data,
    output logic                o_ready,
    output logic                o_valid,
    output pngdf_pkg::t_work    o_data,
    input  logic                i_pop_ready
);
    import pngdf_pkg::*;

    t_work              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr, r_rd;
    logic [QCNT_W-1:0]  r_count, n_count;
    logic               push, pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_push && o_ready;
    assign pop     = i_pop_ready && o_valid;

    always_comb begin
        case ({push, pop})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> r_count == $past(r_count) + QCNT_W'(1))
        else $error("queue count lost a push");

endmodule

@@ sv/pngdf_back.sv @@
// Back end: running CRC-32, received CRC compare and the registered result word.
module pngdf_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  pngdf_pkg::t_work    i_work,
    output logic                o_ready,
    pngdf_out_if.source         o_out
);
    import pngdf_pkg::*;

    logic [31:0] r_crc;
    logic [31:0] r_rx;
    logic        r_vld;
    t_work       r_out;
    logic        r_ok;
    logic        take;
    logic [31:0] crc_upd;
    logic [31:0] rx_sh;
    logic        ok;

    assign o_ready = !r_vld || o_out.ready;
    assign take    = i_valid && o_ready;
    assign crc_upd = crc_byte(r_crc, i_work.byte_val);
    assign rx_sh   = {r_rx[23:0], i_work.byte_val};
    assign ok      = i_work.chunk_last && (rx_sh == ~r_crc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= '1;
            r_rx  <= '0;
            r_vld <= 1'b0;
        end else begin
            if (take) begin
                r_vld <= 1'b1;
                if (i_work.chunk_last) begin
                    r_crc <= '1;
                    r_rx  <= '0;
                end else begin
                    if ((i_work.phase == PH_TYPE) || (i_work.phase == PH_DATA)) begin
                        r_crc <= crc_upd;
                    end
                    if (i_work.phase == PH_CRC) begin
                        r_rx <= rx_sh;
                    end
                end
            end else if (o_out.ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= i_work;
            r_ok  <= ok;
        end
    end

    assign o_out.valid       = r_vld;
    assign o_out.byte_out    = r_out.byte_val;
    assign o_out.phase       = r_out.phase;
    assign o_out.is_required = r_out.is_required;
    assign o_out.chunk_type  = r_out.chunk_type;
    assign o_out.chunk_last  = r_out.chunk_last;
    assign o_out.crc_ok      = r_ok;

    a_ok_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.crc_ok |-> o_out.chunk_last)
        else $error("crc_ok raised off the last byte");

    a_last_in_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.chunk_last |-> o_out.phase == PH_CRC)
        else $error("chunk end outside the crc field");

    a_crc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_work.chunk_last |=> r_crc == 32'hFFFF_FFFF)
        else $error("crc not restarted after chunk end");

endmodule

@@ sv/png_chunk_deframer_crc_check_core.sv @@
// PNG chunk deframer top level: register port, front end, queue and CRC back end.
// Takes a PNG chunk stream (signature removed) one byte per word and returns one result
// word per byte: the byte, its field (length, type, data, crc), the chunk type and a
// required-type flag once the type field is complete, and on the last CRC byte a flag
// telling whether the received CRC-32 matches the one computed over type and data.
// One byte is accepted every clock cycle while the queue has room; each result is written
// to a four-word queue between the field tracker and the CRC unit, and that queue plus the
// output register let either side stall without losing throughput. Registers 0..3 at
// byte addresses 0x0..0xC hold the required type names (big-endian ASCII), register 4 at
// 0x10 the count of names compared, capped at REQUIRED_SLOTS; write them only while idle.
module png_chunk_deframer_crc_check_core #(
    parameter int REQUIRED_SLOTS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    pngdf_in_if.sink                            i_in,
    pngdf_out_if.source                         o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pngdf_pkg::REG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import pngdf_pkg::*;

    logic [31:0]          r_req_type [REQUIRED_SLOTS];
    logic [2:0]           r_in_use;
    logic                 wr;
    logic [REG_IDX_W-1:0] idx;
    logic                 push;
    t_work                work_in;
    logic                 q_ready;
    logic                 q_valid;
    t_work                work_out;
    logic                 back_ready;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[REG_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REQUIRED_SLOTS; i++) begin
                r_req_type[i] <= 32'h0;
            end
            r_in_use <= 3'd0;
        end else if (wr) begin
            for (int i = 0; i < REQUIRED_SLOTS; i++) begin
                if (idx == REG_TYPE_FIRST + REG_IDX_W'(i)) begin
                    r_req_type[i] <= pwdata;
                end
            end
            if (idx == REG_IN_USE) begin
                r_in_use <= pwdata[2:0];
            end
        end
    end

    always_comb begin
        prdata = 32'h0;
        for (int i = 0; i < REQUIRED_SLOTS; i++) begin
            if (idx == REG_TYPE_FIRST + REG_IDX_W'(i)) begin
                prdata = r_req_type[i];
            end
        end
        if (idx == REG_IN_USE) begin
            prdata = {29'h0, r_in_use};
        end
    end

    pngdf_front #(
        .REQUIRED_SLOTS (REQUIRED_SLOTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .i_byte       (i_in.stream_byte),
        .o_ready      (i_in.ready),
        .i_req_type   (r_req_type),
        .i_req_in_use (r_in_use),
        .o_push       (push),
        .o_work       (work_in),
        .i_q_ready    (q_ready)
    );

    pngdf_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (work_in),
        .o_ready     (q_ready),
        .o_valid     (q_valid),
        .o_data      (work_out),
        .i_pop_ready (back_ready)
    );

    pngdf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_work  (work_out),
        .o_ready (back_ready),
        .o_out   (o_out)
    );

endmodule

@@ bench/pngdf_result_check.sv @@
`timescale 1ns / 100ps
// Result checker for the PNG chunk deframer: tracks register writes, predicts and compares each word.
module pngdf_result_check #(
    parameter int REQUIRED_SLOTS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pngdf_in_if                              i_in_ch,
    pngdf_out_if                             i_out_ch,
    input  logic                             i_psel,
    input  logic                             i_penable,
    input  logic                             i_pwrite,
    input  logic                             i_pready,
    input  logic [pngdf_pkg::REG_ADDR_W-1:0] i_paddr,
    input  logic [31:0]                      i_pwdata,
    output int                               o_fail_count,
    output int                               o_pending
);
    import pngdf_pkg::*;

    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [7:0]  byte_val;
        logic [1:0]  phase;
        logic        req;
        logic [31:0] ctype;
        logic        last;
        logic        crc_good;
    } t_chunk_word;

    logic [31:0]      req_names [4];
    logic [2:0]       names_used;

    logic [1:0]       field;
    logic [1:0]       field_pos;
    logic [31:0]      len_acc;
    logic [31:0]      data_left;
    logic [31:0]      type_acc;
    logic [31:0]      crc_acc;
    logic [31:0]      crc_rx;
    logic             type_hit;

    t_chunk_word      pending_results [$];

    initial o_fail_count = 0;

    function automatic logic [31:0] crc32_advance(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'h0, b};
        for (int i = 0; i < 8; i++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic name_required(input logic [31:0] t);
        int n;
        n = (names_used > REQUIRED_SLOTS) ? REQUIRED_SLOTS : names_used;
        for (int i = 0; i < n; i++) begin
            if (req_names[i] == t) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < PRINT_CAP) begin
            $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
        end
        o_fail_count++;
    endtask

    task automatic classify_byte(input logic [7:0] b);
        t_chunk_word e;
        e = '0;
        e.byte_val = b;
        e.phase    = field;
        case (field)
            PH_LENGTH: begin
                len_acc = {len_acc[23:0], b};
                if (field_pos == FIELD_LAST_BYTE) begin
                    field_pos = '0;
                    field     = PH_TYPE;
                    type_acc  = '0;
                    type_hit  = 1'b0;
                end else begin
                    field_pos++;
                end
            end
            PH_TYPE: begin
                type_acc = {type_acc[23:0], b};
                crc_acc  = crc32_advance(crc_acc, b);
                if (field_pos == FIELD_LAST_BYTE) begin
                    field_pos = '0;
                    type_hit  = name_required(type_acc);
                    e.req     = type_hit;
                    e.ctype   = type_acc;
                    data_left = len_acc;
                    field     = (len_acc == 0) ? PH_CRC : PH_DATA;
                end else begin
                    field_pos++;
                end
            end
            PH_DATA: begin
                e.req   = type_hit;
                e.ctype = type_acc;
                crc_acc = crc32_advance(crc_acc, b);
                if (data_left != 0) data_left--;
                if (data_left == 0) begin
                    field_pos = '0;
                    field     = PH_CRC;
                end
            end
            default: begin
                e.req   = type_hit;
                e.ctype = type_acc;
                crc_rx  = {crc_rx[23:0], b};
                if (field_pos == FIELD_LAST_BYTE) begin
                    e.last     = 1'b1;
                    e.crc_good = (crc_rx == ~crc_acc);
                    field_pos  = '0;
                    field      = PH_LENGTH;
                    len_acc    = '0;
                    data_left  = '0;
                    type_acc   = '0;
                    crc_acc    = '1;
                    crc_rx     = '0;
                    type_hit   = 1'b0;
                end else begin
                    field_pos++;
                end
            end
        endcase
        pending_results.push_back(e);
    endtask

    always @(posedge i_clk) begin
        t_chunk_word e;
        logic [REG_IDX_W-1:0] idx;
        if (!i_rst_n) begin
            foreach (req_names[i]) req_names[i] = '0;
            names_used = '0;
            field      = PH_LENGTH;
            field_pos  = '0;
            len_acc    = '0;
            data_left  = '0;
            type_acc   = '0;
            crc_acc    = '1;
            crc_rx     = '0;
            type_hit   = 1'b0;
            pending_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                idx = i_paddr[REG_ADDR_W-1:2];
                if (idx < REG_IN_USE) begin
                    req_names[idx - REG_TYPE_FIRST] = i_pwdata;
                end else if (idx == REG_IN_USE) begin
                    names_used = i_pwdata[2:0];
                end
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                classify_byte(i_in_ch.stream_byte);
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("word with nothing expected, byte_out",
                                    i_out_ch.byte_out, '0);
                end else begin
                    e = pending_results.pop_front();
                    if (i_out_ch.byte_out !== e.byte_val)
                        report_mismatch("byte_out", i_out_ch.byte_out, e.byte_val);
                    if (i_out_ch.phase !== e.phase)
                        report_mismatch("phase", i_out_ch.phase, e.phase);
                    if (i_out_ch.is_required !== e.req)
                        report_mismatch("is_required", i_out_ch.is_required, e.req);
                    if (i_out_ch.chunk_type !== e.ctype)
                        report_mismatch("chunk_type", i_out_ch.chunk_type, e.ctype);
                    if (i_out_ch.chunk_last !== e.last)
                        report_mismatch("chunk_last", i_out_ch.chunk_last, e.last);
                    if (i_out_ch.crc_ok !== e.crc_good)
                        report_mismatch("crc_ok", i_out_ch.crc_ok, e.crc_good);
                end
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

@@ bench/png_chunk_deframer_crc_check_core_test.sv @@
`timescale 1ns / 100ps
// Top-level testbench for the PNG chunk deframer: chunk stimulus, register setup and verdict.
module png_chunk_deframer_crc_check_core_test;
    import pngdf_pkg::*;

    localparam int          LIMIT_CYCLES = 200000;
    localparam int          PHASE_BYTES  = 205;
    localparam logic [31:0] TYPE_IHDR    = "IHDR";
    localparam logic [31:0] TYPE_IDAT    = "IDAT";
    localparam logic [31:0] TYPE_IEND    = "IEND";
    localparam logic [31:0] TYPE_PLTE    = "PLTE";
    localparam logic [31:0] TYPE_TEXT    = "tEXt";
    localparam logic [31:0] TYPE_GAMA    = "gAMA";

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [REG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int                    fail_count;
    int                    pending;
    int                    cycle_count;
    int                    bytes_sent;
    int                    tx_max;
    int                    rx_max;
    int                    rx_hold;
    logic [31:0]           names_now [4];

    pngdf_in_if  in_ch ();
    pngdf_out_if out_ch ();

    png_chunk_deframer_crc_check_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pngdf_result_check #(
        .REQUIRED_SLOTS (4)
    ) result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[png_chunk_deframer_crc_check_core] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        int d;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_hold      <= 0;
        end else if (rx_hold != 0) begin
            rx_hold      <= rx_hold - 1;
            out_ch.ready <= (rx_hold == 1);
        end else if (out_ch.valid && out_ch.ready) begin
            d = $urandom_range(0, rx_max);
            rx_hold      <= d;
            out_ch.ready <= (d == 0);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [31:0] a, input logic [31:0] b,
                                 input logic [31:0] c, input logic [31:0] d,
                                 input logic [31:0] n);
        names_now[0] = a;
        names_now[1] = b;
        names_now[2] = c;
        names_now[3] = d;
        for (int i = 0; i < 4; i++) write_reg(REG_TYPE_FIRST + 3'(i), names_now[i]);
        write_reg(REG_IN_USE, n);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.stream_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic put_chunk(input logic [31:0] len, input logic [31:0] ctype,
                             input int n_data, input logic [31:0] crc_flip);
        logic [31:0] crc;
        logic [7:0]  b;
        crc = '1;
        for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
        for (int i = 3; i >= 0; i--) begin
            b   = ctype[8*i +: 8];
            crc = crc_byte(crc, b);
            send_byte(b);
        end
        for (int i = 0; i < n_data; i++) begin
            b   = $urandom_range(0, 255);
            crc = crc_byte(crc, b);
            send_byte(b);
        end
        if (32'(n_data) == len) begin
            crc = ~crc ^ crc_flip;
            for (int i = 3; i >= 0; i--) send_byte(crc[8*i +: 8]);
        end
    endtask

    function automatic logic [31:0] pick_type();
        logic [31:0] t;
        int          r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            t = names_now[$urandom_range(0, 3)];
        end else if (r < 8) begin
            for (int i = 0; i < 4; i++)
                t[8*i +: 8] = 8'd65 + 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'd32 : 8'd0);
        end else begin
            t = $urandom;
        end
        return t;
    endfunction

    task automatic run_phase(input int tx, input int rx, input logic [31:0] a,
                             input logic [31:0] b, input logic [31:0] c,
                             input logic [31:0] d, input logic [31:0] n);
        int          stop_at;
        int          r;
        logic [31:0] len;
        logic [31:0] flip;
        wait_drained();
        apply_setting(a, b, c, d, n);
        tx_max  = tx;
        rx_max  = rx;
        stop_at = bytes_sent + PHASE_BYTES;
        while (bytes_sent < stop_at) begin
            r = $urandom_range(0, 19);
            if (r == 0) len = 0;
            else if (r == 1) len = $urandom_range(64, 200);
            else len = $urandom_range(1, 24);
            flip = ($urandom_range(0, 4) == 0) ? (32'h1 << $urandom_range(0, 31)) : 32'h0;
            put_chunk(len, pick_type(), len, flip);
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.stream_byte = '0;
        out_ch.ready      = 1'b0;
        cycle_count       = 0;
        bytes_sent        = 0;
        rx_hold           = 0;
        tx_max            = 5;
        rx_max            = 5;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apply_setting(TYPE_IHDR, TYPE_IDAT, TYPE_IEND, TYPE_PLTE, 4);
        put_chunk(32'd0, TYPE_IEND, 0, 32'h0);
        put_chunk(32'd1, 32'hFFFF_FFFF, 1, 32'h8000_0001);

        run_phase(5, 5, TYPE_IHDR, TYPE_IDAT, TYPE_IEND, TYPE_PLTE, 4);
        run_phase(0, 0, 32'h0, 32'hFFFF_FFFF, TYPE_IDAT, TYPE_IDAT, 7);
        run_phase(5, 0, 32'h0, 32'hFFFF_FFFF, TYPE_IDAT, TYPE_IDAT, 0);
        run_phase(0, 5, $urandom, $urandom, TYPE_IHDR, TYPE_IEND, 2);
        run_phase(5, 5, TYPE_TEXT, TYPE_IDAT, TYPE_GAMA, $urandom, 1);
        run_phase(3, 3, TYPE_PLTE, TYPE_GAMA, TYPE_IDAT, TYPE_IHDR, 3);

        // open a chunk with the largest length and stop partway through its data
        put_chunk(32'hFFFF_FFFF, pick_type(), 30, 32'h0);
        wait_drained();
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("[png_chunk_deframer_crc_check_core] OK");
        end else begin
            $display("[png_chunk_deframer_crc_check_core] ERROR");
        end
        $finish;
    end

endmodule

@@ png_chunk_deframer_crc_check_core.f @@
sv/pngdf_pkg.sv
sv/pngdf_in_if.sv
sv/pngdf_out_if.sv
sv/pngdf_front.sv
sv/pngdf_fifo.sv
sv/pngdf_back.sv
sv/png_chunk_deframer_crc_check_core.sv
bench/pngdf_result_check.sv
bench/png_chunk_deframer_crc_check_core_test.sv
